>>> hw/rtl/ipt_pkg.sv
package ipt_pkg;

	// default capacity of the frame table
	localparam int MAX_FRAMES_DEF = 32;

	// field widths
	localparam int PAGE_W   = 16;
	localparam int LADDR_W  = 16;
	localparam int FRAME_W  = 6;
	localparam int PSIZE_W  = 13;
	localparam int FCOUNT_W = 6;
	localparam int BASE_W   = 16;
	localparam int PADDR_W  = 32;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	// register reset values
	localparam logic [PSIZE_W-1:0]  PSIZE_RST  = PSIZE_W'(256);
	localparam logic [FCOUNT_W-1:0] FCOUNT_RST = FCOUNT_W'(32);
	localparam logic [BASE_W-1:0]   BASE_RST   = '0;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd2;

	// operation codes
	localparam logic OP_STORE     = 1'b0;
	localparam logic OP_TRANSLATE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_FRAME  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_MAPPED = 2'd2;

	// divider handshake
	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

>>> hw/rtl/ipt_if.sv
interface ipt_in_if;
	logic                           valid;
	logic                           ready;
	logic                           operation;
	logic [ipt_pkg::FRAME_W-1:0]    frame_number;
	logic [ipt_pkg::PAGE_W-1:0]     page_number;
	logic [ipt_pkg::LADDR_W-1:0]    logical_address;

	modport source (output valid, output operation, output frame_number,
		output page_number, output logical_address, input ready);
	modport sink (input valid, input operation, input frame_number,
		input page_number, input logical_address, output ready);
endinterface

interface ipt_out_if;
	logic                           valid;
	logic                           ready;
	logic [ipt_pkg::PADDR_W-1:0]    physical_address;
	logic [ipt_pkg::STATUS_W-1:0]   status;

	modport source (output valid, output physical_address, output status, input ready);
	modport sink (input valid, input physical_address, input status, output ready);
endinterface

>>> hw/rtl/ipt_ram.sv
module ipt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hw/rtl/ipt_div.sv
module ipt_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ipt_pkg::div_ctl_t            ctl,
	input  logic [ipt_pkg::LADDR_W-1:0]  dividend,
	input  logic [ipt_pkg::PSIZE_W-1:0]  divisor,
	output ipt_pkg::div_sts_t            sts,
	output logic [ipt_pkg::LADDR_W-1:0]  quotient,
	output logic [ipt_pkg::PSIZE_W-1:0]  remainder
);
	import ipt_pkg::*;

	localparam int CNT_W = $clog2(LADDR_W);

	logic [LADDR_W-1:0] quo_q;
	logic [PSIZE_W-1:0] rem_q;
	logic [PSIZE_W-1:0] dsr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [PSIZE_W:0]   trial;
	logic               fits;
	logic [PSIZE_W:0]   diff;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[LADDR_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(LADDR_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, a zero divisor acts as one
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= (divisor == '0) ? PSIZE_W'(1) : divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[LADDR_W-2:0], fits};
			rem_q <= fits ? diff[PSIZE_W-1:0] : trial[PSIZE_W-1:0];
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

>>> hw/rtl/inverted_page_table_translator.sv
// inverted page table translator
// in_ch carries one transaction per operation: a store places page_number
// into frame frame_number, a translate looks up logical_address. out_ch
// returns exactly one transaction per input, in order, with
// physical_address and status (ok, bad frame on store, page not mapped).
// the cfg port writes page_size, frame_count and base_address; the user
// must do so only while idle, the block itself does not enforce it.
// the block handles one operation at a time: in_ch.ready is high only
// when no operation is at work. a store passes from accept through
// S_DONE into the output register. a translate runs logical_address
// through the bit-serial divider, scans the frames in use through the
// page table ram, whose read is registered, until a hit, and on a hit
// does a multiply and an add. in either case the next input can be
// taken as soon as the result is offered.
// if out_ch stalls, the result waits in the output register while the
// next operation is taken and worked; that one holds in S_DONE and no
// further input is taken until the register frees.
// reset clears all frame valid bits and restores the register defaults;
// no clearing pass is needed, the page ram is read only behind valid.
module inverted_page_table_translator #(
	parameter int MAX_FRAMES = ipt_pkg::MAX_FRAMES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ipt_in_if.sink                        in_ch,
	ipt_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [ipt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ipt_pkg::CFG_W-1:0]     cfg_data
);
	import ipt_pkg::*;

	localparam int FW   = $clog2(MAX_FRAMES);
	localparam int CNTW = (FW + 1 > FCOUNT_W) ? FW + 1 : FCOUNT_W;
	localparam int PRW  = FW + PSIZE_W;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_START  = 7'b0000010,
		S_DIV    = 7'b0000100,
		S_SEARCH = 7'b0001000,
		S_MUL    = 7'b0010000,
		S_ADD    = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t state_q;

	logic [PSIZE_W-1:0]  page_size_q;
	logic [FCOUNT_W-1:0] frame_count_q;
	logic [BASE_W-1:0]   base_q;

	logic [MAX_FRAMES-1:0] valid_q;
	logic [CNTW-1:0]       count;
	logic [CNTW-1:0]       fc_ext;
	logic [CNTW-1:0]       frame_ext;
	logic                  accept;
	logic                  store_ok;

	logic [LADDR_W-1:0]  laddr_q;
	logic [CNTW-1:0]     addr_q;
	logic [FW-1:0]       idx_s1;
	logic                pend_s1;
	logic [FW-1:0]       hit_q;
	logic [PRW-1:0]      prod_q;
	logic [PSIZE_W-1:0]  eff_ps;
	logic                hit;

	logic [PADDR_W-1:0]  res_addr_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                out_valid_q;
	logic [PADDR_W-1:0]  out_addr_q;
	logic [STATUS_W-1:0] out_status_q;

	logic [PAGE_W-1:0]   rd_data;
	div_ctl_t            div_ctl;
	div_sts_t            div_sts;
	logic [LADDR_W-1:0]  pno;
	logic [PSIZE_W-1:0]  off;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q   <= PSIZE_RST;
			frame_count_q <= FCOUNT_RST;
			base_q        <= BASE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PAGE_SIZE:    page_size_q   <= cfg_data[PSIZE_W-1:0];
				CFG_FRAME_COUNT:  frame_count_q <= cfg_data[FCOUNT_W-1:0];
				CFG_BASE_ADDRESS: base_q        <= cfg_data[BASE_W-1:0];
				default: ;
			endcase
		end
	end

	// frames in use, capped at capacity
	assign fc_ext    = CNTW'(frame_count_q);
	assign count     = (fc_ext > CNTW'(MAX_FRAMES)) ? CNTW'(MAX_FRAMES) : fc_ext;
	assign frame_ext = CNTW'(in_ch.frame_number);
	assign eff_ps    = (page_size_q == '0) ? PSIZE_W'(1) : page_size_q;

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign store_ok    = accept && (in_ch.operation == OP_STORE) && (frame_ext < count);

	// page table ram
	ipt_ram #(
		.WIDTH(PAGE_W),
		.DEPTH(MAX_FRAMES)
	) u_ram (
		.clk  (clk),
		.we   (store_ok),
		.waddr(frame_ext[FW-1:0]),
		.wdata(in_ch.page_number),
		.raddr(addr_q[FW-1:0]),
		.rdata(rd_data)
	);

	// address split
	assign div_ctl.start = (state_q == S_START);

	ipt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (laddr_q),
		.divisor  (page_size_q),
		.sts      (div_sts),
		.quotient (pno),
		.remainder(off)
	);

	// compare the entry read last cycle
	assign hit = pend_s1 && valid_q[idx_s1] && (rd_data == pno);

	// frame valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (store_ok) begin
			valid_q[frame_ext[FW-1:0]] <= 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_s1 <= 1'b0;
			addr_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (in_ch.operation == OP_TRANSLATE) ? S_START : S_DONE;
					end
				end
				S_START: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_sts.done) begin
						state_q <= S_SEARCH;
						addr_q  <= '0;
						pend_s1 <= 1'b0;
					end
				end
				S_SEARCH: begin
					if (hit) begin
						pend_s1 <= 1'b0;
						state_q <= S_MUL;
					end else if (addr_q < count) begin
						pend_s1 <= 1'b1;
						addr_q  <= addr_q + 1'b1;
					end else begin
						pend_s1 <= 1'b0;
						state_q <= S_DONE;
					end
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			laddr_q      <= in_ch.logical_address;
			res_addr_q   <= '0;
			res_status_q <= (in_ch.operation == OP_STORE && !(frame_ext < count)) ?
				STATUS_BAD_FRAME : STATUS_OK;
		end
		if (state_q == S_SEARCH) begin
			idx_s1 <= addr_q[FW-1:0];
			if (hit) begin
				hit_q <= idx_s1;
			end else if (!(addr_q < count)) begin
				res_status_q <= STATUS_NOT_MAPPED;
			end
		end
		if (state_q == S_MUL) begin
			prod_q <= PRW'(hit_q) * PRW'(eff_ps);
		end
		if (state_q == S_ADD) begin
			res_addr_q <= PADDR_W'(base_q) + PADDR_W'(prod_q) + PADDR_W'(off);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid_q || out_ch.ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || out_ch.ready)) begin
			out_addr_q   <= res_addr_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.physical_address = out_addr_q;
	assign out_ch.status           = out_status_q;

endmodule

>>> hw/rtl/ipt_chk.sv
module ipt_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [ipt_pkg::PADDR_W-1:0]   out_addr,
	input logic [ipt_pkg::STATUS_W-1:0]  out_status
);
	import ipt_pkg::*;

	// a result holds until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// only defined status codes appear
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_status == STATUS_OK || out_status == STATUS_BAD_FRAME ||
			out_status == STATUS_NOT_MAPPED))
		else $error("undefined status code");

	// failed operations carry a zero address
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != STATUS_OK |-> out_addr == '0)
		else $error("nonzero address on failure");

	// one operation at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted while busy");

endmodule

bind inverted_page_table_translator ipt_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_addr  (out_ch.physical_address),
	.out_status(out_ch.status)
);
